// File: hdl/gcaw_pkg.sv
`default_nettype none

package gcaw_pkg;

   localparam int FRAC_W     = 16;
   localparam int PIXEL_W    = FRAC_W + 1;
   localparam int LEVELS     = 256;
   localparam int TOP_LEVEL  = LEVELS - 1;
   localparam int STOP_REGS  = 5;
   localparam int STOPS      = 5;
   localparam int MAX_STOPS  = (STOPS < STOP_REGS) ? STOPS : STOP_REGS;
   localparam int SEGS       = STOP_REGS - 1;
   localparam int SEG_W      = $clog2(SEGS);
   localparam int COUNT_W    = 3;
   localparam int CHANNELS   = 3;
   localparam int DIV_STAGES = 4;
   localparam int DIV_STEPS  = 2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_STOP_0       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_STOP_1       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_STOP_2       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_STOP_3       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_STOP_4       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_STOP_COUNT   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_PALETTE_MODE = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_ALPHA_WINDOW = 3'd7;

   localparam logic MODE_CONTINUOUS = 1'b0;
   localparam logic MODE_SECTIONS   = 1'b1;

   typedef logic [7:0] level_type;
   typedef logic [CHANNELS-1:0][7:0] rgb_type;

   typedef struct packed {
      rgb_type   [SEGS-1:0] seg_start;
      rgb_type   [SEGS-1:0] seg_end;
      level_type [SEGS-1:0] seg_pos;
      level_type [SEGS-1:0] seg_span;
      logic      [SEGS-1:0] seg_live;
      rgb_type              top_rgb;
      logic                 mode;
      level_type            win_lo;
      level_type            win_hi;
   } cfg_type;

   typedef struct packed {
      rgb_type                    base;
      logic [CHANNELS-1:0][8:0]   diff;
      level_type                  off;
      level_type                  span;
      logic                       alpha;
   } seg_type;

   typedef struct packed {
      rgb_type                    base;
      logic [CHANNELS-1:0]        neg;
      rgb_type                    rem;
      rgb_type                    low;
      rgb_type                    quo;
      level_type                  span;
      logic                       alpha;
   } div_type;

endpackage

`default_nettype wire

// File: hdl/gcaw_ifs.sv
`default_nettype none

interface gcaw_req_if;
   import gcaw_pkg::*;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_value;
   modport source (output valid, output pixel_value, input ready);
   modport sink (input valid, input pixel_value, output ready);
endinterface

interface gcaw_rsp_if;
   import gcaw_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;
   modport source (output valid, output red, output green, output blue, output alpha,
                   input ready);
   modport sink (input valid, input red, input green, input blue, input alpha,
                 output ready);
endinterface

interface gcaw_csr_if;
   import gcaw_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/gcaw_front.sv
`default_nettype none

module gcaw_front (
   input  logic                          clock,
   input  logic                          reset,
   input  gcaw_pkg::cfg_type             cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [gcaw_pkg::PIXEL_W-1:0]  pixel_value,
   output logic                          out_valid,
   input  logic                          out_ready,
   output gcaw_pkg::seg_type             out_data
);
   import gcaw_pkg::*;

   logic [PIXEL_W+7:0]  scaled;
   logic [PIXEL_W-9:0]  whole;
   logic [PIXEL_W-8:0]  rounded;
   logic                round_up;
   level_type           level_in;
   level_type           level_ff;
   logic                level_valid_ff;
   logic                level_ready;

   logic [SEG_W-1:0]    seg;
   rgb_type             start_rgb;
   rgb_type             end_rgb;
   logic                flat;
   logic                alpha;
   seg_type             seg_in;
   seg_type             seg_ff;
   logic                seg_valid_ff;
   logic                seg_ready;

   // Gray level: pixel_value * 255 / 2^16, rounded half to even, saturated.
   always_comb begin
      scaled   = {pixel_value, 8'd0} - (PIXEL_W + 8)'(pixel_value);
      whole    = scaled[PIXEL_W+7:FRAC_W];
      round_up = (scaled[FRAC_W-1:0] > {1'b1, {(FRAC_W-1){1'b0}}})
              || ((scaled[FRAC_W-1:0] == {1'b1, {(FRAC_W-1){1'b0}}}) && whole[0]);
      rounded  = {1'b0, whole} + (PIXEL_W - 7)'(round_up);
      level_in = (rounded > (PIXEL_W - 7)'(TOP_LEVEL)) ? level_type'(TOP_LEVEL)
                                                       : rounded[7:0];
   end

   assign level_ready = !level_valid_ff || seg_ready;
   assign in_ready    = level_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_valid_ff <= 1'b0;
      end else if (level_ready) begin
         level_valid_ff <= in_valid;
      end
      if (in_valid && level_ready) begin
         level_ff <= level_in;
      end
   end

   // Segment search, colour selection and the window test.
   always_comb begin
      seg = '0;
      for (int j = 0; j < SEGS; j++) begin
         if (cfg.seg_live[j] && (level_ff >= cfg.seg_pos[j])) begin
            seg = seg + SEG_W'(1);
         end
      end
      start_rgb = cfg.seg_start[seg];
      end_rgb   = cfg.seg_end[seg];
      flat      = (level_ff == level_type'(TOP_LEVEL)) || (cfg.mode == MODE_SECTIONS);

      if (cfg.win_lo <= cfg.win_hi) begin
         alpha = (level_ff >= cfg.win_lo) && (level_ff <= cfg.win_hi);
      end else begin
         alpha = (level_ff > cfg.win_lo) || (level_ff < cfg.win_hi);
      end

      seg_in.base  = (level_ff == level_type'(TOP_LEVEL)) ? cfg.top_rgb : start_rgb;
      seg_in.off   = level_ff - cfg.seg_pos[seg];
      seg_in.span  = cfg.seg_span[seg];
      seg_in.alpha = alpha;
      for (int c = 0; c < CHANNELS; c++) begin
         seg_in.diff[c] = flat ? 9'd0 : ({1'b0, end_rgb[c]} - {1'b0, start_rgb[c]});
      end
   end

   assign seg_ready = !seg_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_valid_ff <= 1'b0;
      end else if (seg_ready) begin
         seg_valid_ff <= level_valid_ff;
      end
      if (level_valid_ff && seg_ready) begin
         seg_ff <= seg_in;
      end
   end

   assign out_valid = seg_valid_ff;
   assign out_data  = seg_ff;

endmodule

`default_nettype wire

// File: hdl/gcaw_mul.sv
`default_nettype none

module gcaw_mul (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  gcaw_pkg::seg_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output gcaw_pkg::div_type out_data
);
   import gcaw_pkg::*;

   logic [7:0]  mag;
   logic [15:0] prod;
   div_type     mul_in;
   div_type     mul_ff;
   logic        valid_ff;

   // The product magnitude is split into the partial remainder (high byte)
   // and the dividend bits still to be brought down (low byte).
   always_comb begin
      mul_in.base  = in_data.base;
      mul_in.span  = in_data.span;
      mul_in.alpha = in_data.alpha;
      mag  = '0;
      prod = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         mag  = in_data.diff[c][8] ? (~in_data.diff[c][7:0] + 8'd1) : in_data.diff[c][7:0];
         prod = 16'(mag) * 16'(in_data.off);
         mul_in.neg[c] = in_data.diff[c][8];
         mul_in.rem[c] = prod[15:8];
         mul_in.low[c] = prod[7:0];
         mul_in.quo[c] = '0;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         mul_ff <= mul_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = mul_ff;

endmodule

`default_nettype wire

// File: hdl/gcaw_div_stage.sv
`default_nettype none

module gcaw_div_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  gcaw_pkg::div_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output gcaw_pkg::div_type out_data
);
   import gcaw_pkg::*;

   logic [8:0] trial;
   logic       take;
   div_type    step_in;
   div_type    step_ff;
   logic       valid_ff;

   // Restoring division, a fixed number of quotient bits per stage.
   always_comb begin
      step_in = in_data;
      trial   = '0;
      take    = 1'b0;
      for (int k = 0; k < DIV_STEPS; k++) begin
         for (int c = 0; c < CHANNELS; c++) begin
            trial = {step_in.rem[c], step_in.low[c][7]};
            take  = trial >= {1'b0, step_in.span};
            step_in.rem[c] = take ? 8'(trial - {1'b0, step_in.span}) : trial[7:0];
            step_in.low[c] = {step_in.low[c][6:0], 1'b0};
            step_in.quo[c] = {step_in.quo[c][6:0], take};
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         step_ff <= step_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = step_ff;

endmodule

`default_nettype wire

// File: hdl/gcaw_out.sv
`default_nettype none

module gcaw_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  gcaw_pkg::div_type in_data,
   gcaw_rsp_if.source        rsp
);
   import gcaw_pkg::*;

   logic [7:0] quot;
   rgb_type    rgb_in;
   rgb_type    rgb_ff;
   logic       alpha_ff;
   logic       valid_ff;

   // A negative product is divided with rounding towards minus infinity,
   // so a nonzero remainder raises the magnitude of the quotient by one.
   always_comb begin
      quot = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         quot = in_data.quo[c] + 8'(in_data.neg[c] && (in_data.rem[c] != 8'd0));
         rgb_in[c] = in_data.neg[c] ? (in_data.base[c] - quot) : (in_data.base[c] + quot);
      end
   end

   assign in_ready = !valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         rgb_ff   <= rgb_in;
         alpha_ff <= in_data.alpha;
      end
   end

   assign rsp.valid = valid_ff;
   assign rsp.red   = rgb_ff[2];
   assign rsp.green = rgb_ff[1];
   assign rsp.blue  = rgb_ff[0];
   assign rsp.alpha = alpha_ff ? 8'hFF : 8'h00;

endmodule

`default_nettype wire

// File: hdl/gradient_colormap_alpha_window_core.sv
`default_nettype none

// Channel   Direction  Payload                        Handshake
// req_bus   in         pixel_value[16:0]              valid / ready
// rsp_bus   out        red, green, blue, alpha [7:0]  valid / ready
// csr_bus   in         index[2:0], data[31:0]         valid / ready (always ready)
//
// One transaction is accepted per clock while the pipeline is not stalled; a
// result passes through registered stages for gray level, segment search,
// product, four division stages of two bits each and the output register.
// Reset is synchronous and empties every stage. Each stage holds its item
// while the one after it is full and stalled, so bubbles are squeezed out.

module gradient_colormap_alpha_window_core (
   input  logic        clock,
   input  logic        reset,
   gcaw_req_if.sink    req_bus,
   gcaw_rsp_if.source  rsp_bus,
   gcaw_csr_if.sink    csr_bus
);
   import gcaw_pkg::*;

   logic [31:0]        stop_ff [STOP_REGS];
   logic [COUNT_W-1:0] count_ff;
   logic               mode_ff;
   logic [15:0]        window_ff;

   logic [COUNT_W-1:0] n_stops;
   level_type          pos [STOP_REGS];
   level_type          pick;
   level_type          span;
   rgb_type            last_rgb;
   rgb_type            prev_rgb;
   cfg_type            cfg_in;
   cfg_type            cfg_ff;

   logic               seg_valid;
   logic               seg_ready;
   seg_type            seg_data;
   logic               div_valid [DIV_STAGES+1];
   logic               div_ready [DIV_STAGES+1];
   div_type            div_data  [DIV_STAGES+1];

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STOP_REGS; i++) begin
            stop_ff[i] <= (i == 1) ? 32'hFFFF_0000 : 32'h0000_0000;
         end
         count_ff   <= 3'd2;
         mode_ff    <= MODE_CONTINUOUS;
         window_ff  <= 16'hFF00;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_STOP_0:       stop_ff[0] <= csr_bus.data;
            REG_STOP_1:       stop_ff[1] <= csr_bus.data;
            REG_STOP_2:       stop_ff[2] <= csr_bus.data;
            REG_STOP_3:       stop_ff[3] <= csr_bus.data;
            REG_STOP_4:       stop_ff[4] <= csr_bus.data;
            REG_STOP_COUNT:   count_ff   <= csr_bus.data[COUNT_W-1:0];
            REG_PALETTE_MODE: mode_ff    <= csr_bus.data[0];
            REG_ALPHA_WINDOW: window_ff  <= csr_bus.data[15:0];
         endcase
      end
   end

   // Segment table derived from the registers: the first stop sits at level
   // zero, the last one in use at the top level, and positions never fall.
   always_comb begin
      if (count_ff < 3'd2) begin
         n_stops = 3'd2;
      end else if (count_ff > COUNT_W'(MAX_STOPS)) begin
         n_stops = COUNT_W'(MAX_STOPS);
      end else begin
         n_stops = count_ff;
      end

      pos[0] = '0;
      for (int i = 1; i < STOP_REGS; i++) begin
         pick   = (COUNT_W'(i) == n_stops - 3'd1) ? level_type'(TOP_LEVEL)
                                                  : stop_ff[i][31:24];
         pos[i] = (pick > pos[i-1]) ? pick : pos[i-1];
      end

      last_rgb = '0;
      prev_rgb = '0;
      for (int i = 0; i < STOP_REGS; i++) begin
         if (COUNT_W'(i) == n_stops - 3'd1) begin
            last_rgb = stop_ff[i][23:0];
         end
         if (COUNT_W'(i) == n_stops - 3'd2) begin
            prev_rgb = stop_ff[i][23:0];
         end
      end

      span = '0;
      for (int j = 0; j < SEGS; j++) begin
         span               = pos[j+1] - pos[j];
         cfg_in.seg_start[j] = stop_ff[j][23:0];
         cfg_in.seg_end[j]   = stop_ff[j+1][23:0];
         cfg_in.seg_pos[j]   = pos[j];
         cfg_in.seg_span[j]  = (span == 8'd0) ? 8'd1 : span;
         cfg_in.seg_live[j]  = (j != 0) && (COUNT_W'(j) + 3'd2 <= n_stops);
      end
      cfg_in.top_rgb = (mode_ff == MODE_SECTIONS) ? prev_rgb : last_rgb;
      cfg_in.mode    = mode_ff;
      cfg_in.win_lo  = window_ff[7:0];
      cfg_in.win_hi  = window_ff[15:8];
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   gcaw_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req_bus.valid),
      .in_ready    (req_bus.ready),
      .pixel_value (req_bus.pixel_value),
      .out_valid   (seg_valid),
      .out_ready   (seg_ready),
      .out_data    (seg_data)
   );

   gcaw_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (seg_valid),
      .in_ready  (seg_ready),
      .in_data   (seg_data),
      .out_valid (div_valid[0]),
      .out_ready (div_ready[0]),
      .out_data  (div_data[0])
   );

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      gcaw_div_stage u_div_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[g]),
         .in_ready  (div_ready[g]),
         .in_data   (div_data[g]),
         .out_valid (div_valid[g+1]),
         .out_ready (div_ready[g+1]),
         .out_data  (div_data[g+1])
      );
   end

   gcaw_out u_out (
      .clock    (clock),
      .reset    (reset),
      .in_valid (div_valid[DIV_STAGES]),
      .in_ready (div_ready[DIV_STAGES]),
      .in_data  (div_data[DIV_STAGES]),
      .rsp      (rsp_bus)
   );

   a_span_nonzero : assert property (@(posedge clock) disable iff (reset)
      seg_valid |-> (seg_data.span != 8'd0))
      else $error("Segment span of zero reached the multiplier.");

   a_quotient_fits : assert property (@(posedge clock) disable iff (reset)
      div_valid[0] |-> ((div_data[0].rem[0] < div_data[0].span)
                     && (div_data[0].rem[1] < div_data[0].span)
                     && (div_data[0].rem[2] < div_data[0].span)))
      else $error("Product too large for an eight-bit quotient.");

   a_remainder_bound : assert property (@(posedge clock) disable iff (reset)
      div_valid[DIV_STAGES] |-> ((div_data[DIV_STAGES].rem[0] < div_data[DIV_STAGES].span)
                              && (div_data[DIV_STAGES].rem[1] < div_data[DIV_STAGES].span)
                              && (div_data[DIV_STAGES].rem[2] < div_data[DIV_STAGES].span)))
      else $error("Final remainder not below the span.");

endmodule

`default_nettype wire
